### rtl/ternary_weight_sign_accumulate_unit_macros.svh
// Assertion macros used by the checker file of the sign accumulate unit.
`ifndef TERNARY_WEIGHT_SIGN_ACCUMULATE_UNIT_MACROS_SVH
`define TERNARY_WEIGHT_SIGN_ACCUMULATE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TWSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed: same-cycle rule");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TWSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed: next-cycle rule");

`endif

### rtl/twsa_pkg.sv
// Types and constants shared by the sign accumulate unit.
package twsa_pkg;

    localparam int IDX_W     = 12;
    localparam int GRAD_W    = 16;
    localparam int ACT_W     = 8;
    localparam int ACC_W     = 16;
    localparam int WT_W      = 2;
    localparam int DIR_W     = 2;
    localparam int THR_W     = 15;
    localparam int CFG_IDX_W = 1;

    // Register indexes on the config port.
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE      = 1'd1;

    localparam logic [THR_W-1:0] THR_RESET    = 15'd16;
    localparam logic [THR_W-1:0] DZ_RESET     = 15'd0;
    localparam logic [THR_W-1:0] FREEZE_LEVEL = 15'd30000;

    // Two-bit signed step and weight codes.
    localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;
    localparam logic [DIR_W-1:0] DIR_DN   = 2'b11;
    localparam logic [WT_W-1:0]  WT_ZERO  = 2'b00;
    localparam logic [WT_W-1:0]  WT_POS   = 2'b01;
    localparam logic [WT_W-1:0]  WT_NEG   = 2'b11;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    // One memory word: accumulator and ternary weight of one index.
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [WT_W-1:0]  weight;
    } t_entry;

    typedef struct packed {
        t_entry           entry;
        logic [DIR_W-1:0] step;
    } t_upd;

endpackage

### rtl/ternary_weight_sign_accumulate_unit.sv
// Top level of the ternary weight sign accumulate unit: pipeline, forwarding, clear pass.
// A word accepted is held in the update stage registers, then in the output register
// until the receiver takes it. Throughput: one word per cycle while the receiver takes
// results, set by the single read-modify-write of the state memory; a write-back forward
// covers back-to-back words on the same index. Reset: synchronous, active low; after it,
// a clearing pass zeroes every entry, o_in_ready low; config writes are taken meanwhile.
module ternary_weight_sign_accumulate_unit #(
    parameter int WEIGHT_COUNT = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config port
    input  logic                                 i_cfg_we,
    input  logic [twsa_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [twsa_pkg::THR_W-1:0]           i_cfg_data,
    // input word channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [twsa_pkg::IDX_W-1:0]           i_weight_index,
    input  logic signed [twsa_pkg::GRAD_W-1:0]   i_gradient,
    input  logic signed [twsa_pkg::ACT_W-1:0]    i_activation,
    // result word channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [twsa_pkg::DIR_W-1:0]    o_step_direction,
    output logic signed [twsa_pkg::WT_W-1:0]     o_new_weight
);

    localparam int AW = $clog2(WEIGHT_COUNT);
    // Index width wide enough for both the port and the memory address.
    localparam int XW = (AW > twsa_pkg::IDX_W) ? AW : twsa_pkg::IDX_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(WEIGHT_COUNT - 1);

    // Config registers.
    logic [twsa_pkg::THR_W-1:0] r_step_threshold;
    logic [twsa_pkg::THR_W-1:0] r_dead_zone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_threshold <= twsa_pkg::THR_RESET;
            r_dead_zone      <= twsa_pkg::DZ_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                twsa_pkg::CFG_STEP_THRESHOLD: r_step_threshold <= i_cfg_data;
                twsa_pkg::CFG_DEAD_ZONE:      r_dead_zone      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Clear sequencer: sweep every entry to zero after reset, then run.
    twsa_pkg::t_state r_state;
    twsa_pkg::t_state n_state;
    logic [AW-1:0]    r_clr_addr;
    logic             clr_active;

    always_comb begin
        n_state = r_state;
        case (r_state)
            twsa_pkg::ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = twsa_pkg::ST_RUN;
                end
            end
            twsa_pkg::ST_RUN: n_state = twsa_pkg::ST_RUN;
            default:          n_state = twsa_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        case (r_state)
            twsa_pkg::ST_CLEAR: clr_active = 1'b1;
            default:            clr_active = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= twsa_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clr_active) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // Front stage: decode index and the step direction -(sign(g) * sign(a)).
    logic [XW-1:0]              idx_x;
    logic [AW-1:0]              in_addr;
    logic                       in_range;
    logic [twsa_pkg::GRAD_W:0]  grad_mag;
    logic                       has_sign;
    logic [twsa_pkg::DIR_W-1:0] in_dir;
    logic                       in_accept;

    always_comb begin
        idx_x    = XW'(i_weight_index);
        in_addr  = idx_x[AW-1:0];
        in_range = 32'(i_weight_index) < 32'(WEIGHT_COUNT);
        grad_mag = i_gradient[twsa_pkg::GRAD_W-1]
                 ? (twsa_pkg::GRAD_W + 1)'(0) - {1'b1, i_gradient}
                 : {1'b0, i_gradient};
        has_sign = (grad_mag > (twsa_pkg::GRAD_W + 1)'(r_dead_zone))
                && (i_activation != '0);
        if (!has_sign) begin
            in_dir = twsa_pkg::DIR_NONE;
        end else if (i_gradient[twsa_pkg::GRAD_W-1] != i_activation[twsa_pkg::ACT_W-1]) begin
            in_dir = twsa_pkg::DIR_UP;
        end else begin
            in_dir = twsa_pkg::DIR_DN;
        end
    end

    // Update stage registers: the word whose memory read is in flight.
    logic                       r_s1_valid;
    logic [AW-1:0]              r_s1_addr;
    logic                       r_s1_in_range;
    logic [twsa_pkg::DIR_W-1:0] r_s1_dir;
    logic                       s1_advance;

    // Output register.
    logic                       r_out_valid;
    logic [twsa_pkg::DIR_W-1:0] r_out_step;
    logic [twsa_pkg::WT_W-1:0]  r_out_weight;

    assign s1_advance = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !clr_active && (!r_s1_valid || s1_advance);
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_addr     <= in_addr;
            r_s1_in_range <= in_range;
            r_s1_dir      <= in_dir;
        end
    end

    // State memory and write-back.
    twsa_pkg::t_entry mem_rdata;
    twsa_pkg::t_entry mem_wdata;
    logic [AW-1:0]    mem_waddr;
    logic             mem_we;
    twsa_pkg::t_entry operand;
    twsa_pkg::t_upd   upd;
    logic             frozen;
    logic             wb_we;

    // Last write-back made: its address holds the newest word, so forward it
    // whenever the update stage works on the same entry.
    logic             r_fwd_valid;
    logic [AW-1:0]    r_fwd_addr;
    twsa_pkg::t_entry r_fwd_data;

    assign frozen  = r_step_threshold >= twsa_pkg::FREEZE_LEVEL;
    assign operand = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : mem_rdata;
    assign wb_we   = s1_advance && r_s1_in_range && !frozen;

    always_comb begin
        if (clr_active) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = wb_we;
            mem_waddr = r_s1_addr;
            mem_wdata = upd.entry;
        end
    end

    twsa_update u_update (
        .i_entry     (operand),
        .i_dir       (r_s1_dir),
        .i_threshold (r_step_threshold),
        .i_frozen    (frozen),
        .o_result    (upd)
    );

    twsa_mem #(
        .DEPTH (WEIGHT_COUNT)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (in_accept),
        .i_raddr (in_addr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (wb_we) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_we) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= upd.entry;
        end
    end

    // Output register: load on advance, drop once the word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            if (r_s1_in_range) begin
                r_out_step   <= upd.step;
                r_out_weight <= upd.entry.weight;
            end else begin
                // Out-of-range index: report no step and a zero weight.
                r_out_step   <= twsa_pkg::DIR_NONE;
                r_out_weight <= twsa_pkg::WT_ZERO;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_step_direction = r_out_step;
    assign o_new_weight     = r_out_weight;

endmodule

### rtl/twsa_mem.sv
// Single-port-write, registered-read state memory of the sign accumulate unit.
module twsa_mem #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  twsa_pkg::t_entry         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output twsa_pkg::t_entry         o_rdata
);

    twsa_pkg::t_entry r_mem [DEPTH];
    twsa_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read returns the old word when the same entry is written in this cycle.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/twsa_update.sv
// Accumulator step, threshold test and saturating weight step for one word.
module twsa_update (
    input  twsa_pkg::t_entry                  i_entry,
    input  logic [twsa_pkg::DIR_W-1:0]        i_dir,
    input  logic [twsa_pkg::THR_W-1:0]        i_threshold,
    input  logic                              i_frozen,
    output twsa_pkg::t_upd                    o_result
);

    logic [twsa_pkg::THR_W-1:0] thr_eff;
    logic [twsa_pkg::ACC_W-1:0] acc_up;
    logic [twsa_pkg::ACC_W-1:0] acc_dn;
    logic [twsa_pkg::ACC_W:0]   thr_pos;
    logic [twsa_pkg::ACC_W:0]   thr_neg;
    logic                       hit_up;
    logic                       hit_dn;

    always_comb begin
        thr_eff = (i_threshold == '0) ? twsa_pkg::THR_W'(1) : i_threshold;
        acc_up  = i_entry.acc + twsa_pkg::ACC_W'(1);
        acc_dn  = i_entry.acc - twsa_pkg::ACC_W'(1);
        thr_pos = {2'b00, thr_eff};
        thr_neg = (twsa_pkg::ACC_W + 1)'(0) - thr_pos;
        hit_up  = $signed({acc_up[twsa_pkg::ACC_W-1], acc_up}) >= $signed(thr_pos);
        hit_dn  = $signed({acc_dn[twsa_pkg::ACC_W-1], acc_dn}) <= $signed(thr_neg);
    end

    always_comb begin
        o_result.entry = i_entry;
        o_result.step  = twsa_pkg::DIR_NONE;
        if (!i_frozen) begin
            case (i_dir)
                twsa_pkg::DIR_UP: begin
                    if (hit_up) begin
                        o_result.entry.acc = '0;
                        o_result.step      = twsa_pkg::DIR_UP;
                        if (i_entry.weight != twsa_pkg::WT_POS) begin
                            o_result.entry.weight = i_entry.weight + twsa_pkg::WT_W'(1);
                        end
                    end else begin
                        o_result.entry.acc = acc_up;
                    end
                end
                twsa_pkg::DIR_DN: begin
                    if (hit_dn) begin
                        o_result.entry.acc = '0;
                        o_result.step      = twsa_pkg::DIR_DN;
                        if (i_entry.weight != twsa_pkg::WT_NEG) begin
                            o_result.entry.weight = i_entry.weight - twsa_pkg::WT_W'(1);
                        end
                    end else begin
                        o_result.entry.acc = acc_dn;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### rtl/twsa_checker.sv
// Port-level checker of the sign accumulate unit and its bind.
`include "ternary_weight_sign_accumulate_unit_macros.svh"

module twsa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [twsa_pkg::DIR_W-1:0]    o_step_direction,
    input logic [twsa_pkg::WT_W-1:0]     o_new_weight
);

    // An up step never leaves a negative weight.
    `TWSA_ASSERT_NOW(a_up_not_neg, o_out_valid && (o_step_direction == twsa_pkg::DIR_UP), o_new_weight != twsa_pkg::WT_NEG)

    // A down step never leaves a positive weight.
    `TWSA_ASSERT_NOW(a_dn_not_pos, o_out_valid && (o_step_direction == twsa_pkg::DIR_DN), o_new_weight != twsa_pkg::WT_POS)

    // Weight stays ternary.
    `TWSA_ASSERT_NOW(a_wt_ternary, o_out_valid, (o_new_weight == twsa_pkg::WT_ZERO) || (o_new_weight == twsa_pkg::WT_POS) || (o_new_weight == twsa_pkg::WT_NEG))

    // Hold a stalled result word.
    `TWSA_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_step_direction) && $stable(o_new_weight))

endmodule

bind ternary_weight_sign_accumulate_unit twsa_checker u_twsa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_step_direction (o_step_direction),
    .o_new_weight     (o_new_weight)
);

### verif/tb_ternary_weight_sign_accumulate_unit.sv
// Self-checking testbench for the ternary weight sign accumulate unit.
`timescale 1ns / 1ps

module tb_ternary_weight_sign_accumulate_unit;

    localparam int N_WEIGHTS = 4096;

    // One result word: step applied and the weight left behind.
    typedef struct packed {
        logic signed [twsa_pkg::DIR_W-1:0] step;
        logic signed [twsa_pkg::WT_W-1:0]  weight;
    } t_update_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [twsa_pkg::CFG_IDX_W-1:0]      i_cfg_index = twsa_pkg::CFG_STEP_THRESHOLD;
    logic [twsa_pkg::THR_W-1:0]          i_cfg_data = '0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_ready;
    logic [twsa_pkg::IDX_W-1:0]          i_weight_index = '0;
    logic signed [twsa_pkg::GRAD_W-1:0]  i_gradient = '0;
    logic signed [twsa_pkg::ACT_W-1:0]   i_activation = '0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    logic signed [twsa_pkg::DIR_W-1:0]   o_step_direction;
    logic signed [twsa_pkg::WT_W-1:0]    o_new_weight;

    // Shadow copy of the unit's state and registers.
    logic signed [twsa_pkg::ACC_W-1:0]   acc_model [N_WEIGHTS];
    logic [twsa_pkg::WT_W-1:0]           weight_model [N_WEIGHTS];
    logic [twsa_pkg::THR_W-1:0]          thr_model;
    logic [twsa_pkg::THR_W-1:0]          dz_model;

    t_update_result            pending_results [$];
    t_update_result            oldest_result;
    int                        mismatch_count = 0;
    int                        burst_left = 0;
    int                        stall_tick = 0;
    int                        stall_mode = 0;

    ternary_weight_sign_accumulate_unit #(
        .WEIGHT_COUNT (N_WEIGHTS)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_weight_index   (i_weight_index),
        .i_gradient       (i_gradient),
        .i_activation     (i_activation),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_step_direction (o_step_direction),
        .o_new_weight     (o_new_weight)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    //------------------------------------------------------------------
    // Shadow model
    //------------------------------------------------------------------

    function automatic void clear_model();
        for (int i = 0; i < N_WEIGHTS; i++) begin
            acc_model[i]    = '0;
            weight_model[i] = twsa_pkg::WT_ZERO;
        end
        thr_model = twsa_pkg::THR_RESET;
        dz_model  = twsa_pkg::DZ_RESET;
    endfunction

    // Apply one word to the shadow state and return the result it must produce.
    function automatic t_update_result predict_update(
        input logic [twsa_pkg::IDX_W-1:0]         idx,
        input logic signed [twsa_pkg::GRAD_W-1:0] grad,
        input logic signed [twsa_pkg::ACT_W-1:0]  act
    );
        t_update_result                    res;
        int                                eff_thr;
        int                                grad_i;
        int                                mag;
        int                                g_sign;
        int                                a_sign;
        int                                move;
        logic signed [twsa_pkg::ACC_W-1:0] acc;
        logic [twsa_pkg::WT_W-1:0]         wt;

        res.step   = twsa_pkg::DIR_NONE;
        res.weight = twsa_pkg::WT_ZERO;
        // Out-of-range index: word is dropped, both fields read zero.
        if (int'(idx) >= N_WEIGHTS)
            return res;
        wt = weight_model[idx];
        // Frozen threshold leaves every store untouched.
        if (thr_model < twsa_pkg::FREEZE_LEVEL) begin
            eff_thr = (thr_model == '0) ? 1 : int'(thr_model);
            grad_i  = int'(grad);
            mag     = (grad_i < 0) ? -grad_i : grad_i;
            g_sign  = (mag <= int'(dz_model)) ? 0 : ((grad_i > 0) ? 1 : -1);
            a_sign  = (act > 0) ? 1 : ((act < 0) ? -1 : 0);
            // Accumulator moves against the sign product.
            move = -(g_sign * a_sign);
            acc  = acc_model[idx];
            if (move > 0) begin
                acc = acc + 16'sd1;
                if (int'(acc) >= eff_thr) begin
                    acc      = '0;
                    res.step = twsa_pkg::DIR_UP;
                end
            end else if (move < 0) begin
                acc = acc - 16'sd1;
                if (int'(acc) <= -eff_thr) begin
                    acc      = '0;
                    res.step = twsa_pkg::DIR_DN;
                end
            end
            acc_model[idx] = acc;
            // Step the ternary weight, saturating at either end.
            if (res.step == twsa_pkg::DIR_UP && wt != twsa_pkg::WT_POS)
                wt = (wt == twsa_pkg::WT_NEG) ? twsa_pkg::WT_ZERO : twsa_pkg::WT_POS;
            else if (res.step == twsa_pkg::DIR_DN && wt != twsa_pkg::WT_NEG)
                wt = (wt == twsa_pkg::WT_POS) ? twsa_pkg::WT_ZERO : twsa_pkg::WT_NEG;
            weight_model[idx] = wt;
        end
        res.weight = wt;
        return res;
    endfunction

    //------------------------------------------------------------------
    // Drivers
    //------------------------------------------------------------------

    // Write one register; called at a falling edge while the unit is idle.
    task automatic write_register(input logic [twsa_pkg::CFG_IDX_W-1:0] index,
                                  input logic [twsa_pkg::THR_W-1:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(posedge i_clk);
        case (index)
            twsa_pkg::CFG_STEP_THRESHOLD: thr_model = value;
            twsa_pkg::CFG_DEAD_ZONE:      dz_model  = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Send one word; called at a falling edge, returns at a falling edge.
    task automatic send_word(input logic [twsa_pkg::IDX_W-1:0] idx,
                             input logic signed [twsa_pkg::GRAD_W-1:0] grad,
                             input logic signed [twsa_pkg::ACT_W-1:0] act);
        int gap;

        // Open a new burst after a random gap; a zero gap keeps words back to back.
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 6));
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = int'($urandom_range(1, 16));
        end
        i_weight_index = idx;
        i_gradient     = grad;
        i_activation   = act;
        i_in_valid     = 1'b1;
        // Hold the word until the unit takes it.
        do
            @(posedge i_clk);
        while (!o_in_ready);
        pending_results.push_back(predict_update(idx, grad, act));
        burst_left--;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Pause the sender until every expected word has come back.
    task automatic wait_for_results();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Receiver: stall on a pattern that is redrawn at random from four modes.
    always @(negedge i_clk) begin
        stall_tick++;
        if (stall_tick % 64 == 0)
            stall_mode = int'($urandom_range(0, 3));
        case (stall_mode)
            0:       i_out_ready = 1'b1;
            1:       i_out_ready = 1'($urandom_range(0, 1));
            2:       i_out_ready = (stall_tick % 4 == 0);
            default: i_out_ready = ($urandom_range(0, 7) == 0);
        endcase
    end

    //------------------------------------------------------------------
    // Result checker
    //------------------------------------------------------------------

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Compare each taken result word against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("unexpected word step=%0d weight=%0d",
                                        o_step_direction, o_new_weight));
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_step_direction !== oldest_result.step)
                    note_mismatch($sformatf("step_direction expected %0d got %0d",
                                            oldest_result.step, o_step_direction));
                if (o_new_weight !== oldest_result.weight)
                    note_mismatch($sformatf("new_weight expected %0d got %0d",
                                            oldest_result.weight, o_new_weight));
            end
        end
    end

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Field extremes, zero gradient and zero activation at reset settings.
    task automatic test_reset_defaults();
        send_word(12'd0,    16'sd32767,  8'sd127);
        send_word(12'd4095, 16'sh8000,   8'sh80);
        send_word(12'd1,    16'sd0,      8'sd5);
        send_word(12'd2,    16'sd100,    8'sd0);
        send_word(12'd3,    16'sd1,      -8'sd1);
        send_word(12'd4,    -16'sd1,     8'sd1);
        wait_for_results();
    endtask

    // Zero threshold acts as one: every signed word steps; drive into both rails.
    task automatic test_saturation();
        write_register(twsa_pkg::CFG_STEP_THRESHOLD, 15'd0);
        repeat (2) send_word(12'd7, -16'sd512, 8'sd64);
        repeat (3) send_word(12'd7, 16'sd512, 8'sd64);
        wait_for_results();
        write_register(twsa_pkg::CFG_STEP_THRESHOLD, 15'd2);
        repeat (2) send_word(12'd8, 16'sd300, 8'sd3);
        wait_for_results();
    endtask

    // Gradients right at and just beyond the dead zone, including the widest zone.
    task automatic test_dead_zone();
        write_register(twsa_pkg::CFG_STEP_THRESHOLD, 15'd1);
        write_register(twsa_pkg::CFG_DEAD_ZONE, 15'd100);
        send_word(12'd9, 16'sd100,  8'sd1);
        send_word(12'd9, -16'sd100, 8'sd1);
        send_word(12'd9, 16'sd101,  -8'sd1);
        send_word(12'd9, -16'sd101, -8'sd1);
        wait_for_results();
        write_register(twsa_pkg::CFG_DEAD_ZONE, 15'd32767);
        send_word(12'd9, 16'sh8000,   8'sd127);
        send_word(12'd9, 16'sd32767,  8'sh80);
        wait_for_results();
        write_register(twsa_pkg::CFG_DEAD_ZONE, 15'd0);
    endtask

    // Build up a count, then lower the threshold below it.
    task automatic test_lowered_threshold();
        write_register(twsa_pkg::CFG_STEP_THRESHOLD, 15'd8);
        repeat (5) send_word(12'd10, -16'sd40, 8'sd9);
        wait_for_results();
        write_register(twsa_pkg::CFG_STEP_THRESHOLD, 15'd3);
        send_word(12'd10, -16'sd40, 8'sd9);
        wait_for_results();
    endtask

    // Thresholds at and above the freeze level leave the stores alone.
    task automatic test_freeze();
        write_register(twsa_pkg::CFG_STEP_THRESHOLD, twsa_pkg::FREEZE_LEVEL);
        send_word(12'd7, -16'sd1000, 8'sd1);
        wait_for_results();
        write_register(twsa_pkg::CFG_STEP_THRESHOLD, 15'd32767);
        send_word(12'd8, 16'sd1000, 8'sd1);
        wait_for_results();
    endtask

    // Phases of biased random words over small index windows, new settings per phase.
    task automatic test_random_stream();
        int                                 mode;
        int                                 mag;
        int                                 mag_a;
        int                                 base;
        bit                                 bias_up;
        bit                                 go_up;
        bit                                 a_neg;
        bit                                 g_neg;
        logic [twsa_pkg::IDX_W-1:0]         idx;
        logic signed [twsa_pkg::GRAD_W-1:0] grad;
        logic signed [twsa_pkg::ACT_W-1:0]  act;
        logic [twsa_pkg::THR_W-1:0]         thr;
        logic [twsa_pkg::THR_W-1:0]         dz;

        for (int phase = 0; phase < 10; phase++) begin
            mode = int'($urandom_range(0, 9));
            case (mode)
                0:       thr = 15'd0;
                1:       thr = twsa_pkg::THR_W'(int'(twsa_pkg::FREEZE_LEVEL)
                                              + int'($urandom_range(0, 2767)));
                2:       thr = 15'd29999;
                3:       thr = twsa_pkg::THR_W'($urandom_range(1, 40));
                default: thr = twsa_pkg::THR_W'($urandom_range(1, 6));
            endcase
            mode = int'($urandom_range(0, 9));
            case (mode)
                0:       dz = 15'd32767;
                1:       dz = twsa_pkg::THR_W'($urandom_range(0, 32767));
                default: dz = twsa_pkg::THR_W'($urandom_range(0, 300));
            endcase
            write_register(twsa_pkg::CFG_STEP_THRESHOLD, thr);
            write_register(twsa_pkg::CFG_DEAD_ZONE, dz);
            bias_up = 1'($urandom_range(0, 1));
            base    = int'($urandom_range(0, N_WEIGHTS - 8));

            for (int n = 0; n < 70; n++) begin
                // Drain the pipe once mid-phase to hit a fully idle restart.
                if (phase == 4 && n == 35)
                    wait_for_results();
                // Stay mostly in a small window so counts build up.
                if ($urandom_range(0, 4) == 0)
                    idx = twsa_pkg::IDX_W'($urandom_range(0, N_WEIGHTS - 1));
                else
                    idx = twsa_pkg::IDX_W'(base + int'($urandom_range(0, 7)));

                a_neg = 1'($urandom_range(0, 1));
                mode  = int'($urandom_range(0, 9));
                if (mode == 0) begin
                    act = '0;
                end else if (mode == 1) begin
                    act = twsa_pkg::ACT_W'($urandom_range(0, 255));
                end else begin
                    mag_a = a_neg ? int'($urandom_range(1, 128))
                                  : int'($urandom_range(1, 127));
                    act   = twsa_pkg::ACT_W'(a_neg ? -mag_a : mag_a);
                end

                // Odd indexes lean the other way, so both rails get reached.
                go_up = bias_up ^ idx[0];
                if ($urandom_range(0, 3) == 0)
                    g_neg = 1'($urandom_range(0, 1));
                else
                    g_neg = go_up ? !a_neg : a_neg;

                mode = int'($urandom_range(0, 9));
                case (mode)
                    1:       mag = int'(dz_model);
                    2:       mag = int'(dz_model) + 1;
                    3:       mag = g_neg ? 32768 : 32767;
                    default: mag = int'(dz_model) + 1 + int'($urandom_range(0, 2000));
                endcase
                if (mag > 32768 || (!g_neg && mag > 32767))
                    mag = 32767;
                grad = twsa_pkg::GRAD_W'(g_neg ? -mag : mag);
                if (mode == 0)
                    grad = twsa_pkg::GRAD_W'($urandom_range(0, 65535));

                send_word(idx, grad, act);
            end
            wait_for_results();
        end
    endtask

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------

    initial begin
        clear_model();
        // Hold reset, then release it; the unit runs its clearing pass on its own.
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_saturation();
        test_dead_zone();
        test_lowered_threshold();
        test_freeze();
        test_random_stream();

        // Let any stray word show up before the verdict.
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### ternary_weight_sign_accumulate_unit.f
+incdir+rtl
rtl/twsa_pkg.sv
rtl/twsa_mem.sv
rtl/twsa_update.sv
rtl/ternary_weight_sign_accumulate_unit.sv
rtl/twsa_checker.sv
verif/tb_ternary_weight_sign_accumulate_unit.sv
